// File: hw/rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types, constants and the CRC-16 byte step for the IMU frame deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int WIN_LEN   = 36;	// sync byte plus frame body
	localparam int BODY_LEN  = 35;	// bytes after sync
	localparam int CRC_SPAN  = 33;	// body bytes covered by the CRC
	localparam int OUT_WORDS = 7;
	localparam int WORD_BASE = 5;	// body byte of the first output word

	localparam logic [7:0] SYNC_RESET = 8'hFA;

	typedef logic [BODY_LEN-1:0][7:0] body_t;

	// result of one frame check, back to front
	typedef struct packed {
		logic valid;
		logic match;
	} verdict_t;

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_CRC   = 3'b010,
		B_CHECK = 3'b100
	} back_state_t;

	// CRC-16 CCITT, byte-serial form
	function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
	                                           input logic [7:0] data);
		logic [15:0] c;
		c = {crc_in[7:0], crc_in[15:8]};
		c = c ^ {8'h00, data};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

// File: hw/rtl/dfr_job_fifo.sv
// ----------------------------------------------------------------------------
// dfr_job_fifo
// Two-entry queue of candidate frame bodies between front and back.
// ----------------------------------------------------------------------------
module dfr_job_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dfr_pkg::body_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output dfr_pkg::body_t  pop_data
);

	dfr_pkg::body_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !valid))
		else $error("job queue overrun or underrun");

endmodule

// File: hw/rtl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Byte window, fill count and skip count; picks sync-led candidates and
// holds further bytes until the back end has judged the frame.
// ----------------------------------------------------------------------------
module dfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic [7:0]         rx_byte,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               job_push,
	output dfr_pkg::body_t     job_data,
	input  logic               job_full,
	input  dfr_pkg::verdict_t  verdict
);

	localparam logic [5:0] WIN_FULL = 6'(dfr_pkg::WIN_LEN);
	localparam logic [5:0] SKIP_LEN = 6'(dfr_pkg::BODY_LEN);

	logic [dfr_pkg::WIN_LEN-1:0][7:0] win_q;
	logic [dfr_pkg::WIN_LEN-1:0][7:0] win_next;
	logic [5:0] fill_q;
	logic [5:0] fill_next;
	logic [5:0] skip_q;
	logic [7:0] sync_q;
	logic       pending_q;
	logic       accept;
	logic       full_next;

	assign in_stall  = pending_q | job_full;
	assign accept    = in_valid & ~in_stall;
	// index 0 is the oldest byte
	assign win_next  = {rx_byte, win_q[dfr_pkg::WIN_LEN-1:1]};
	assign fill_next = (fill_q == WIN_FULL) ? WIN_FULL : fill_q + 6'd1;
	assign full_next = (fill_next == WIN_FULL);
	assign job_push  = accept & full_next & (skip_q == 6'd0) & (win_next[0] == sync_q);
	assign job_data  = win_next[dfr_pkg::WIN_LEN-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 6'd0;
			skip_q    <= 6'd0;
			sync_q    <= dfr_pkg::SYNC_RESET;
			pending_q <= 1'b0;
		end else begin
			if (cfg_we)
				sync_q <= cfg_wdata;
			if (accept) begin
				fill_q <= fill_next;
				if (full_next && skip_q != 6'd0)
					skip_q <= skip_q - 6'd1;
			end
			if (job_push)
				pending_q <= 1'b1;
			else if (verdict.valid) begin
				pending_q <= 1'b0;
				if (verdict.match)
					skip_q <= SKIP_LEN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			win_q <= win_next;
	end

	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> pending_q && !accept)
		else $error("byte taken while a frame check is open");

	a_verdict_expected: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid |-> pending_q)
		else $error("verdict without an open check");

endmodule

// File: hw/rtl/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Byte-serial CRC-16 over a candidate body, compare with the trailing CRC,
// and on a match load the seven little-endian words into the output register.
// ----------------------------------------------------------------------------
module dfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  dfr_pkg::body_t     job_data,
	output logic               job_pop,
	output dfr_pkg::verdict_t  verdict,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        yaw_bits,
	output logic [31:0]        pitch_bits,
	output logic [31:0]        roll_bits,
	output logic [31:0]        accel_x_bits,
	output logic [31:0]        accel_y_bits,
	output logic [31:0]        accel_z_bits,
	output logic [31:0]        pressure_bits
);

	localparam logic [5:0] LAST_STEP = 6'(dfr_pkg::CRC_SPAN - 1);
	// after CRC_SPAN rotations body byte i sits at i + 2, the CRC at 0 and 1
	localparam int OFS = dfr_pkg::BODY_LEN - dfr_pkg::CRC_SPAN + dfr_pkg::WORD_BASE;

	dfr_pkg::back_state_t state_q;
	dfr_pkg::body_t       sr_q;
	logic [5:0]           step_q;
	logic [15:0]          crc_q;
	logic                 out_valid_q;
	logic [dfr_pkg::OUT_WORDS-1:0][31:0] words_q;
	logic                 match;
	logic                 out_free;
	logic                 load;

	assign job_pop  = (state_q == dfr_pkg::B_IDLE) & job_valid;
	assign match    = (crc_q == {sr_q[0], sr_q[1]});
	assign out_free = ~out_valid_q | ~out_stall;
	assign load     = (state_q == dfr_pkg::B_CHECK) & match & out_free;

	assign verdict.valid = (state_q == dfr_pkg::B_CHECK) & (~match | out_free);
	assign verdict.match = match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfr_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				dfr_pkg::B_IDLE: begin
					if (job_valid)
						state_q <= dfr_pkg::B_CRC;
				end
				dfr_pkg::B_CRC: begin
					if (step_q == LAST_STEP)
						state_q <= dfr_pkg::B_CHECK;
				end
				dfr_pkg::B_CHECK: begin
					if (verdict.valid)
						state_q <= dfr_pkg::B_IDLE;
				end
				default: state_q <= dfr_pkg::B_IDLE;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			sr_q   <= job_data;
			crc_q  <= 16'h0000;
			step_q <= 6'd0;
		end else if (state_q == dfr_pkg::B_CRC) begin
			crc_q  <= dfr_pkg::crc16_step(crc_q, sr_q[0]);
			sr_q   <= {sr_q[0], sr_q[dfr_pkg::BODY_LEN-1:1]};
			step_q <= step_q + 6'd1;
		end
		if (load) begin
			for (int j = 0; j < dfr_pkg::OUT_WORDS; j++)
				words_q[j] <= sr_q[OFS + 4*j +: 4];
		end
	end

	assign out_valid     = out_valid_q;
	assign yaw_bits      = words_q[0];
	assign pitch_bits    = words_q[1];
	assign roll_bits     = words_q[2];
	assign accel_x_bits  = words_q[3];
	assign accel_y_bits  = words_q[4];
	assign accel_z_bits  = words_q[5];
	assign pressure_bits = words_q[6];

	a_crc_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfr_pkg::B_CRC && step_q == LAST_STEP) |=> state_q == dfr_pkg::B_CHECK)
		else $error("CRC pass not of frame length");

	a_match_output: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict.valid && verdict.match) |=> out_valid_q)
		else $error("accepted frame without output transfer pending");

endmodule

// File: hw/rtl/imu_binary_frame_deframer.sv
// ----------------------------------------------------------------------------
// imu_binary_frame_deframer
// Sync-byte frame parser with CRC-16 check for a binary IMU byte stream.
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on rx_byte and fill a 36-byte window. Once the
// window is full, an oldest byte equal to sync_value (reset 0xFA, written via
// cfg_we/cfg_wdata) starts a check: CRC-16 CCITT (init 0) over the 33 bytes
// after sync against the big-endian CRC that follows. A good frame gives one
// output transfer of seven raw little-endian float words and its 35 body bytes
// are then not taken as starts. A byte that starts no check does not raise
// in_stall. A byte that starts a check holds in_stall high while it leaves the
// queue, while 33 CRC steps run at one byte per cycle, and while the frame is
// compared and the verdict handed back; only then is the next byte taken. A
// good frame also waits for the output register to be free, so a stalled
// output stalls the input after one pending result.
// ----------------------------------------------------------------------------
module imu_binary_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] yaw_bits,
	output logic [31:0] pitch_bits,
	output logic [31:0] roll_bits,
	output logic [31:0] accel_x_bits,
	output logic [31:0] accel_y_bits,
	output logic [31:0] accel_z_bits,
	output logic [31:0] pressure_bits
);

	logic              push;
	dfr_pkg::body_t    push_data;
	logic              q_full;
	logic              pop;
	logic              q_valid;
	dfr_pkg::body_t    pop_data;
	dfr_pkg::verdict_t verdict;

	dfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (rx_byte),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.job_push  (push),
		.job_data  (push_data),
		.job_full  (q_full),
		.verdict   (verdict)
	);

	dfr_job_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	dfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_valid),
		.job_data      (pop_data),
		.job_pop       (pop),
		.verdict       (verdict),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.yaw_bits      (yaw_bits),
		.pitch_bits    (pitch_bits),
		.roll_bits     (roll_bits),
		.accel_x_bits  (accel_x_bits),
		.accel_y_bits  (accel_y_bits),
		.accel_z_bits  (accel_z_bits),
		.pressure_bits (pressure_bits)
	);

endmodule
